FILE: rtl/hkfc_pkg.sv
// ----------------------------------------------------------------------------
// hkfc_pkg
// Shared types, codes and constants of the hashed key frequency counter.
// ----------------------------------------------------------------------------
`default_nettype none

package hkfc_pkg;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam int unsigned FNV_SHIFT = 40;          // prime = 2^40 + 0x1b3
  localparam logic [8:0]  FNV_LOW   = 9'h1b3;
  localparam logic [30:0] COUNT_MAX = 31'h7fffffff;
  localparam logic [31:0] ADDS_MAX  = 32'hffffffff;
  localparam int unsigned LOAD_NUM  = 7;
  localparam int unsigned LOAD_DEN  = 10;

  typedef enum logic [2:0] {
    ST_COUNTED = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_FULL    = 3'd2,
    ST_RANKED  = 3'd3,
    ST_NONE    = 3'd4
  } hkfc_status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_KEYCHK, S_HASH, S_PROBE_RD, S_PROBE_CHK,
    S_REP_CHK, S_SCAN, S_SCAN_END, S_EMIT
  } hkfc_state_t;

  typedef struct packed {
    logic         used;
    logic [30:0]  cnt;
    logic [63:0]  key;
  } hkfc_slot_t;

  typedef struct packed {
    logic         accept;
    logic         hash_step;
    logic         probe_start;
    logic         probe_rd;
    logic         probe_next;
    logic         do_ins;
    logic         do_inc;
    logic         scan_start;
    logic         scan_rd;
    logic         clr_wr;
    logic         emit;
    hkfc_status_t emit_status;
  } hkfc_cmd_t;

  typedef struct packed {
    logic key_zero;
    logic hash_done;
    logic slot_used;
    logic key_match;
    logic load_full;
    logic n_zero;
    logic scan_last;
    logic rank_last;
    logic out_free;
  } hkfc_stat_t;

endpackage

`default_nettype wire

FILE: rtl/hkfc_if.sv
// ----------------------------------------------------------------------------
// hkfc_in_if / hkfc_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface hkfc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] key_text;
  logic [6:0]  top_count;
  modport source (output valid, req_type, key_text, top_count, input ready);
  modport sink   (input valid, req_type, key_text, top_count, output ready);
endinterface

interface hkfc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] entry_key;
  logic [30:0] entry_count;
  logic [5:0]  rank;
  logic        last;
  logic [11:0] distinct_keys;
  logic [31:0] total_adds;
  modport source (output valid, status, entry_key, entry_count, rank, last,
                  distinct_keys, total_adds, input ready);
  modport sink   (input valid, status, entry_key, entry_count, rank, last,
                  distinct_keys, total_adds, output ready);
endinterface

`default_nettype wire

FILE: rtl/hkfc_ctrl.sv
// ----------------------------------------------------------------------------
// hkfc_ctrl
// Sequencer for clear, hash, probe, scan and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module hkfc_ctrl (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  input  wire               in_req_type,
  output logic              in_ready,
  input  hkfc_pkg::hkfc_stat_t st,
  output hkfc_pkg::hkfc_cmd_t  cmd
);
  import hkfc_pkg::*;

  hkfc_state_t  state_r, state_nxt;
  hkfc_status_t pend_r, pend_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      pend_r  <= ST_COUNTED;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd             = '0;
    cmd.emit_status = pend_r;
    state_nxt       = state_r;
    pend_nxt        = pend_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.scan_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_req_type ? S_REP_CHK : S_KEYCHK;
        end
      end
      S_KEYCHK: begin
        if (st.key_zero) begin
          pend_nxt  = ST_EMPTY;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: begin
        if (st.hash_done) begin
          cmd.probe_start = 1'b1;
          state_nxt       = S_PROBE_RD;
        end else begin
          cmd.hash_step = 1'b1;
        end
      end
      S_PROBE_RD: begin
        cmd.probe_rd = 1'b1;
        state_nxt    = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (!st.slot_used) begin
          if (st.load_full) begin
            pend_nxt = ST_FULL;
          end else begin
            cmd.do_ins = 1'b1;
            pend_nxt   = ST_COUNTED;
          end
          state_nxt = S_EMIT;
        end else if (st.key_match) begin
          cmd.do_inc = 1'b1;
          pend_nxt   = ST_COUNTED;
          state_nxt  = S_EMIT;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = S_PROBE_RD;
        end
      end
      S_REP_CHK: begin
        if (st.n_zero) begin
          pend_nxt  = ST_NONE;
          state_nxt = S_EMIT;
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_last) state_nxt = S_SCAN_END;
      end
      S_SCAN_END: begin
        pend_nxt  = ST_RANKED;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit = 1'b1;
          if (pend_r == ST_RANKED && !st.rank_last) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/hkfc_datapath.sv
// ----------------------------------------------------------------------------
// hkfc_datapath
// Key normalizer, serial hash, slot memory, rank scan and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module hkfc_datapath #(
  parameter int unsigned TABLE_SLOTS = 2048,
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned RANK_MAX    = 64
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [63:0]         in_key_text,
  input  wire  [6:0]          in_top_count,
  input  hkfc_pkg::hkfc_cmd_t cmd,
  output hkfc_pkg::hkfc_stat_t st,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [2:0]          out_status,
  output logic [63:0]         out_entry_key,
  output logic [30:0]         out_entry_count,
  output logic [5:0]          out_rank,
  output logic                out_last,
  output logic [11:0]         out_distinct_keys,
  output logic [31:0]         out_total_adds
);
  import hkfc_pkg::*;

  localparam int unsigned IW         = $clog2(TABLE_SLOTS);
  localparam int unsigned DW         = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned LOAD_LIMIT = (TABLE_SLOTS * LOAD_NUM) / LOAD_DEN;

  function automatic logic [63:0] norm_key(input logic [63:0] k);
    logic [63:0] r;
    logic        alive;
    r     = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      alive = alive && (i < KEY_BYTES) && (k[8*i +: 8] != 8'd0);
      if (alive) r[8*i +: 8] = k[8*i +: 8];
    end
    return r;
  endfunction

  // low byte is most significant for ordering
  function automatic logic [63:0] swap_bytes(input logic [63:0] k);
    logic [63:0] r;
    for (int i = 0; i < 8; i++) r[8*i +: 8] = k[8*(7-i) +: 8];
    return r;
  endfunction

  function automatic logic ranks_before(input logic [30:0] ca, input logic [63:0] ka,
                                        input logic [30:0] cb, input logic [63:0] kb);
    if (ca != cb) return ca > cb;
    return swap_bytes(ka) < swap_bytes(kb);
  endfunction

  hkfc_slot_t  mem [TABLE_SLOTS];
  hkfc_slot_t  rd_data_r;

  logic [63:0] key_r, hk_r, hash_r;
  logic [IW-1:0] slot_idx_r, scan_idx_r;
  logic          rdv_r;
  logic [DW-1:0] distinct_r;
  logic [31:0]   adds_r;
  logic [6:0]    n_r, rank_r;
  logic          have_r;
  logic [30:0]   best_cnt_r, prev_cnt_r, res_cnt_r;
  logic [63:0]   best_key_r, prev_key_r;

  logic          out_valid_r;
  logic [2:0]    status_r;
  logic [63:0]   okey_r;
  logic [30:0]   ocnt_r;
  logic [5:0]    orank_r;
  logic          olast_r;
  logic [11:0]   odist_r;
  logic [31:0]   oadds_r;

  // hash step: h = (h ^ b) * prime, prime split into shift plus small product
  logic [63:0] h_x, h_mul;
  assign h_x   = hash_r ^ {56'd0, hk_r[7:0]};
  assign h_mul = (h_x << FNV_SHIFT) + (h_x * {55'd0, FNV_LOW});

  logic [30:0] inc_cnt;
  assign inc_cnt = (rd_data_r.cnt == COUNT_MAX) ? COUNT_MAX : rd_data_r.cnt + 31'd1;

  logic [31:0] adds_inc;
  assign adds_inc = (adds_r == ADDS_MAX) ? ADDS_MAX : adds_r + 32'd1;

  logic [31:0] dist_out;
  assign dist_out = 32'(distinct_r);

  // wanted result count at accept
  logic [31:0] top_q, dist_w, n_w;
  always_comb begin
    top_q  = (32'(in_top_count) > RANK_MAX) ? RANK_MAX : 32'(in_top_count);
    dist_w = 32'(distinct_r);
    n_w    = (top_q < dist_w) ? top_q : dist_w;
  end

  logic take;
  assign take = rdv_r && rd_data_r.used &&
                (rank_r == 7'd0 ||
                 ranks_before(prev_cnt_r, prev_key_r, rd_data_r.cnt, rd_data_r.key)) &&
                (!have_r ||
                 ranks_before(rd_data_r.cnt, rd_data_r.key, best_cnt_r, best_key_r));

  logic [7:0] rank_inc;
  assign rank_inc = {1'b0, rank_r} + 8'd1;

  // memory ports
  logic          rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  hkfc_slot_t    wr_data;
  always_comb begin
    rd_en   = cmd.probe_rd | cmd.scan_rd;
    rd_addr = cmd.scan_rd ? scan_idx_r : slot_idx_r;
    wr_en   = cmd.clr_wr | cmd.do_ins | cmd.do_inc;
    wr_addr = cmd.clr_wr ? scan_idx_r : slot_idx_r;
    wr_data = '0;
    if (cmd.do_ins) wr_data = '{used: 1'b1, cnt: 31'd1, key: key_r};
    if (cmd.do_inc) wr_data = '{used: 1'b1, cnt: inc_cnt, key: key_r};
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r  <= '0;
      rdv_r       <= 1'b0;
      distinct_r  <= '0;
      adds_r      <= '0;
      rank_r      <= '0;
      n_r         <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rdv_r <= cmd.scan_rd;
      if (cmd.clr_wr || cmd.scan_rd) scan_idx_r <= scan_idx_r + IW'(1);
      if (cmd.scan_start) begin
        scan_idx_r <= '0;
        have_r     <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
      if (cmd.accept) begin
        n_r    <= n_w[6:0];
        rank_r <= '0;
      end else if (cmd.emit && cmd.emit_status == ST_RANKED) begin
        rank_r <= rank_inc[6:0];
      end
      if (cmd.do_ins) distinct_r <= distinct_r + DW'(1);
      if (cmd.do_ins || cmd.do_inc) adds_r <= adds_inc;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      key_r  <= norm_key(in_key_text);
      hk_r   <= norm_key(in_key_text);
      hash_r <= FNV_BASIS;
    end else if (cmd.hash_step) begin
      hk_r   <= hk_r >> 8;
      hash_r <= h_mul;
    end
    if (cmd.probe_start) slot_idx_r <= hash_r[IW-1:0];
    else if (cmd.probe_next) slot_idx_r <= slot_idx_r + IW'(1);
    if (cmd.do_ins) res_cnt_r <= 31'd1;
    if (cmd.do_inc) res_cnt_r <= inc_cnt;
    if (take) begin
      best_cnt_r <= rd_data_r.cnt;
      best_key_r <= rd_data_r.key;
    end
    if (cmd.emit) begin
      status_r <= cmd.emit_status;
      orank_r  <= '0;
      olast_r  <= 1'b1;
      // totals frozen with the beat so a following request cannot move them
      odist_r  <= dist_out[11:0];
      oadds_r  <= adds_r;
      case (cmd.emit_status)
        ST_COUNTED: begin
          okey_r <= key_r;
          ocnt_r <= res_cnt_r;
        end
        ST_FULL: begin
          okey_r <= key_r;
          ocnt_r <= '0;
        end
        ST_RANKED: begin
          okey_r     <= best_key_r;
          ocnt_r     <= best_cnt_r;
          orank_r    <= rank_r[5:0];
          olast_r    <= (rank_inc == {1'b0, n_r});
          prev_cnt_r <= best_cnt_r;
          prev_key_r <= best_key_r;
        end
        default: begin
          okey_r <= '0;
          ocnt_r <= '0;
        end
      endcase
    end
  end

  always_comb begin
    st.key_zero  = (key_r == 64'd0);
    st.hash_done = (hk_r[7:0] == 8'd0);
    st.slot_used = rd_data_r.used;
    st.key_match = (rd_data_r.key == key_r);
    st.load_full = (dist_w + 32'd1) > LOAD_LIMIT;
    st.n_zero    = (n_r == 7'd0);
    st.scan_last = (scan_idx_r == {IW{1'b1}});
    st.rank_last = (rank_inc == {1'b0, n_r});
    st.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_entry_key     = okey_r;
  assign out_entry_count   = ocnt_r;
  assign out_rank          = orank_r;
  assign out_last          = olast_r;
  assign out_distinct_keys = odist_r;
  assign out_total_adds    = oadds_r;

endmodule

`default_nettype wire

FILE: rtl/hashed_key_frequency_counter.sv
// add request: key check, hash loop over the key bytes, one read and check per probe, then the result beat
// report request: one full table scan per ranked entry, as the slot memory has
//   a single read port
// throughput: one request at a time; next request taken once the last result is queued
// reset: synchronous active-low; afterwards a clearing pass over all TABLE_SLOTS slots
//   empties the slot memory, input ready stays low until it ends
// ----------------------------------------------------------------------------
// hashed_key_frequency_counter
// Counts short text keys in an FNV-1a hashed, linearly probed table and
// reports the most frequent keys on request.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_key_frequency_counter #(
  parameter int unsigned TABLE_SLOTS = 2048,   // power of two
  parameter int unsigned KEY_BYTES   = 8,
  parameter int unsigned RANK_MAX    = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  hkfc_in_if.sink      in_ch,
  hkfc_out_if.source   out_ch
);
  import hkfc_pkg::*;

  hkfc_cmd_t  cmd;   // controller to datapath commands
  hkfc_stat_t st;    // datapath flags back to the controller

  // sequencer: clear pass, hash loop, probe loop, scan rounds, result beats
  hkfc_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .st          (st),
    .cmd         (cmd)
  );

  // slot memory, hash unit, ranking compare and result register
  hkfc_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .RANK_MAX    (RANK_MAX)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_key_text       (in_ch.key_text),
    .in_top_count      (in_ch.top_count),
    .cmd               (cmd),
    .st                (st),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_status        (out_ch.status),
    .out_entry_key     (out_ch.entry_key),
    .out_entry_count   (out_ch.entry_count),
    .out_rank          (out_ch.rank),
    .out_last          (out_ch.last),
    .out_distinct_keys (out_ch.distinct_keys),
    .out_total_adds    (out_ch.total_adds)
  );

endmodule

`default_nettype wire

FILE: rtl/hkfc_checker.sv
// ----------------------------------------------------------------------------
// hkfc_checker
// Port-level checks of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hkfc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [2:0]  status,
  input wire [63:0] entry_key,
  input wire [30:0] entry_count,
  input wire [5:0]  rank,
  input wire        last,
  input wire [11:0] distinct_keys
);
  import hkfc_pkg::*;

  // a pending beat is not withdrawn
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  // add and empty-report beats are single, final, rank zero
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_RANKED |-> last && rank == 6'd0)
    else $error("non-ranked beat not final");

  // ranked entries come from a nonempty table and have nonzero counts
  a_ranked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == ST_RANKED |-> distinct_keys != 12'd0 && entry_count != 31'd0)
    else $error("ranked entry from empty table");

  // rejected empty key and empty report echo nothing
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == ST_EMPTY || status == ST_NONE) |->
      entry_key == 64'd0 && entry_count == 31'd0)
    else $error("empty result carries data");

endmodule

bind hashed_key_frequency_counter hkfc_checker u_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .entry_key     (out_ch.entry_key),
  .entry_count   (out_ch.entry_count),
  .rank          (out_ch.rank),
  .last          (out_ch.last),
  .distinct_keys (out_ch.distinct_keys)
);

`default_nettype wire
